>>> rtl/afm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_pkg: shared types and constants of the 2-D affine matrix unit
// Operation codes, the command carried from the front to the back, and the
// default values of the top-level parameters.
// ----------------------------------------------------------------------------
package afm_pkg;

    // Operation codes as they arrive in the item's tuser field.
    localparam logic [2:0] OP_IDENTITY  = 3'd0;
    localparam logic [2:0] OP_TRANSLATE = 3'd1;
    localparam logic [2:0] OP_SCALE     = 3'd2;
    localparam logic [2:0] OP_ROTATE    = 3'd3;
    localparam logic [2:0] OP_TRANSFORM = 3'd4;

    localparam int AFM_FRAC_BITS   = 12;
    localparam int AFM_SINE_STEPS  = 4096;
    localparam int AFM_QUEUE_DEPTH = 4;

    // pi in Q30, used to build the sine table at elaboration.
    localparam longint unsigned AFM_PI_Q30 = 64'd3373259426;

    // One decoded item on its way from the front to the back.
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic        last;
    } t_afm_cmd;

endpackage

>>> rtl/afm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_front: input stage of the affine matrix unit
// Accepts items, drops unknown operation codes and reduces the angle operand
// modulo the sine table length in two pipeline stages.
// ----------------------------------------------------------------------------
module afm_front #(
    parameter int SINE_STEPS = afm_pkg::AFM_SINE_STEPS,
    parameter int IW         = $clog2(SINE_STEPS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic [2:0]        i_func,
    input  logic [15:0]       i_arg_a,
    input  logic [15:0]       i_arg_b,
    input  logic              i_last,
    output logic              o_push,
    output afm_pkg::t_afm_cmd o_cmd,
    output logic [IW-1:0]     o_angle,
    input  logic              i_full
);

    // Exact floor(a / SINE_STEPS) for any 16-bit a as (a * RECIP) >> K.
    localparam int              K      = 16 + IW;
    localparam longint unsigned RECIP  = ((64'd1 << K) + SINE_STEPS - 1) / SINE_STEPS;
    localparam int              MW     = $clog2(RECIP + 1);
    localparam int              QW     = 16 - IW + 1;

    logic              r_s1_vld;
    afm_pkg::t_afm_cmd r_s1_cmd;
    logic [QW-1:0]     r_s1_q;
    logic              r_s2_vld;
    afm_pkg::t_afm_cmd r_s2_cmd;
    logic [IW-1:0]     r_s2_angle;

    logic              w_adv;
    logic              w_known;
    logic [16+MW-1:0]  w_prod;
    logic [15:0]       w_qs;
    logic [15:0]       w_rem;

    // The two stages move together; they stall only when the queue is full.
    assign w_adv  = !r_s2_vld || !i_full;
    assign o_rdy  = w_adv;
    assign o_push = r_s2_vld && !i_full;

    assign w_known = (i_func == afm_pkg::OP_IDENTITY) || (i_func == afm_pkg::OP_TRANSLATE) ||
                     (i_func == afm_pkg::OP_SCALE) || (i_func == afm_pkg::OP_ROTATE) ||
                     (i_func == afm_pkg::OP_TRANSFORM);

    assign w_prod = (16+MW)'(i_arg_a) * (16+MW)'(RECIP);
    assign w_qs   = 16'(r_s1_q) * 16'(SINE_STEPS);
    assign w_rem  = r_s1_cmd.arg_a - w_qs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_vld && w_known;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_cmd   <= '{op: i_func, arg_a: i_arg_a, arg_b: i_arg_b, last: i_last};
            r_s1_q     <= w_prod[K +: QW];
            r_s2_cmd   <= r_s1_cmd;
            r_s2_angle <= w_rem[IW-1:0];
        end
    end

    assign o_cmd   = r_s2_cmd;
    assign o_angle = r_s2_angle;

endmodule

>>> rtl/afm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_queue: short command queue between front and back
// A small register FIFO so that either side can stall on its own.
// ----------------------------------------------------------------------------
module afm_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = afm_pkg::AFM_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_vld,
    output logic [DATA_W-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_full = (r_count == CW'(DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/afm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afm_back: execution stage of the affine matrix unit
// Reads sine and cosine from the table, updates the matrix and maps points
// into a registered result slot.
// ----------------------------------------------------------------------------
module afm_back #(
    parameter int FRAC_BITS  = afm_pkg::AFM_FRAC_BITS,
    parameter int SINE_STEPS = afm_pkg::AFM_SINE_STEPS,
    parameter int IW         = $clog2(SINE_STEPS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_vld,
    input  afm_pkg::t_afm_cmd i_cmd,
    input  logic [IW-1:0]     i_angle,
    output logic              o_pop,
    output logic              o_vld,
    input  logic              i_rdy,
    output logic [15:0]       o_x,
    output logic [15:0]       o_y,
    output logic              o_last
);

    localparam longint unsigned STEPS64 = 64'(SINE_STEPS);
    localparam logic [15:0]     ONE     = 16'(1 << FRAC_BITS);

    // Sine entry, rounded half away from zero, from a Taylor series in Q30.
    function automatic logic [15:0] sine_entry(input int unsigned idx);
        longint unsigned j, n, x, x2, term, mag;
        longint          sum;
        logic            neg;
        j   = 64'(idx);
        neg = 1'b0;
        if (2 * j >= STEPS64) begin
            j   = j - STEPS64 / 2;
            neg = 1'b1;
            if (2 * j >= STEPS64) begin
                j = 0;
            end
        end
        n = 2 * j;
        if (2 * n > STEPS64) begin
            n = (n <= STEPS64) ? STEPS64 - n : 64'd0;
        end
        x    = (afm_pkg::AFM_PI_Q30 * n + STEPS64 / 2) / STEPS64;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 272; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 342; sum = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        mag = (((64'(sum)) << FRAC_BITS) + (64'd1 << 29)) >> 30;
        if (neg) begin
            return 16'(64'h10000 - mag);
        end
        return 16'(mag);
    endfunction

    function automatic logic [15:0] nrm(input logic signed [31:0] v);
        logic signed [31:0] sh;
        sh = v >>> FRAC_BITS;
        return sh[15:0];
    endfunction

    logic [15:0] w_sine_tab [SINE_STEPS];

    for (genvar g = 0; g < SINE_STEPS; g++) begin : g_sine
        assign w_sine_tab[g] = sine_entry(g);
    end

    // Read stage
    logic              r_r_vld;
    afm_pkg::t_afm_cmd r_r_cmd;
    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;

    // Matrix state
    logic signed [15:0] r_l00, r_l01, r_l10, r_l11, r_off_x, r_off_y;
    logic signed [15:0] n_l00, n_l01, n_l10, n_l11, n_off_x, n_off_y;

    // Result slot
    logic        r_out_vld;
    logic [15:0] r_out_x, r_out_y;
    logic        r_out_last;

    logic              w_exec;
    logic              w_load;
    logic              w_emit;
    logic [IW:0]       w_cos_sum;
    logic [IW-1:0]     w_cos_idx;
    logic              w_rot;
    logic signed [15:0] w_a, w_b, w_op0, w_op1;
    logic signed [31:0] w_p00, w_p01, w_p02, w_p03;
    logic signed [31:0] w_p10, w_p11, w_p12, w_p13;
    logic [15:0]        w_px, w_py;

    // A transform needs the result slot; matrix operations never wait.
    assign w_exec = r_r_vld && ((r_r_cmd.op != afm_pkg::OP_TRANSFORM) || !r_out_vld || i_rdy);
    assign w_load = !r_r_vld || w_exec;
    assign o_pop  = w_load && i_cmd_vld;
    assign w_emit = w_exec && (r_r_cmd.op == afm_pkg::OP_TRANSFORM);

    assign w_cos_sum = {1'b0, i_angle} + (IW+1)'(SINE_STEPS / 4);
    assign w_cos_idx = (w_cos_sum >= (IW+1)'(SINE_STEPS)) ?
                       IW'(w_cos_sum - (IW+1)'(SINE_STEPS)) : w_cos_sum[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld <= 1'b0;
        end else if (w_load) begin
            r_r_vld <= i_cmd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_r_cmd <= i_cmd;
            r_sin   <= $signed(w_sine_tab[i_angle]);
            r_cos   <= $signed(w_sine_tab[w_cos_idx]);
        end
    end

    // Products of both rows; the first two serve scale, rotate and transform.
    assign w_rot = (r_r_cmd.op == afm_pkg::OP_ROTATE);
    assign w_a   = $signed(r_r_cmd.arg_a);
    assign w_b   = $signed(r_r_cmd.arg_b);
    assign w_op0 = w_rot ? r_cos : w_a;
    assign w_op1 = w_rot ? r_sin : w_b;

    assign w_p00 = r_l00 * w_op0;
    assign w_p01 = r_l01 * w_op1;
    assign w_p02 = r_l00 * r_sin;
    assign w_p03 = r_l01 * r_cos;
    assign w_p10 = r_l10 * w_op0;
    assign w_p11 = r_l11 * w_op1;
    assign w_p12 = r_l10 * r_sin;
    assign w_p13 = r_l11 * r_cos;

    assign w_px = nrm(w_p00 + w_p01) + r_off_x;
    assign w_py = nrm(w_p10 + w_p11) + r_off_y;

    always_comb begin
        n_l00   = r_l00;
        n_l01   = r_l01;
        n_l10   = r_l10;
        n_l11   = r_l11;
        n_off_x = r_off_x;
        n_off_y = r_off_y;
        if (w_exec) begin
            case (r_r_cmd.op)
                afm_pkg::OP_IDENTITY: begin
                    n_l00   = ONE;
                    n_l01   = '0;
                    n_l10   = '0;
                    n_l11   = ONE;
                    n_off_x = '0;
                    n_off_y = '0;
                end
                afm_pkg::OP_TRANSLATE: begin
                    n_off_x = r_off_x + w_a;
                    n_off_y = r_off_y + w_b;
                end
                afm_pkg::OP_SCALE: begin
                    n_l00 = nrm(w_p00);
                    n_l01 = nrm(w_p01);
                    n_l10 = nrm(w_p10);
                    n_l11 = nrm(w_p11);
                end
                afm_pkg::OP_ROTATE: begin
                    n_l00 = nrm(w_p00 - w_p01);
                    n_l01 = nrm(w_p02 + w_p03);
                    n_l10 = nrm(w_p10 - w_p11);
                    n_l11 = nrm(w_p12 + w_p13);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l00     <= ONE;
            r_l01     <= '0;
            r_l10     <= '0;
            r_l11     <= ONE;
            r_off_x   <= '0;
            r_off_y   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_l00   <= n_l00;
            r_l01   <= n_l01;
            r_l10   <= n_l10;
            r_l11   <= n_l11;
            r_off_x <= n_off_x;
            r_off_y <= n_off_y;
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_x    <= w_px;
            r_out_y    <= w_py;
            r_out_last <= r_r_cmd.last;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_x    = r_out_x;
    assign o_y    = r_out_y;
    assign o_last = r_out_last;

endmodule

>>> rtl/affine_2d_matrix_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_2d_matrix_unit: fixed-point 2-D affine transform engine
// Holds a 2x3 affine matrix, applies identity, translate, scale and rotate
// commands to it, and maps streamed points through it.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle, matrix commands and points alike,
// as long as the result side keeps up; a point whose result cannot leave yet
// stalls only the back end, and the four-entry command queue keeps the input
// open meanwhile. A point passes five registers in order: two front stages
// that reduce the rotation angle, the queue, the sine table read, and the
// stage that does the multiplies and sums into the result register. The first
// of them is loaded at the accepting edge itself. Each input item carries an
// operation code in tuser (0 identity, 1 translate, 2 scale, 3 rotate,
// 4 transform point); codes 5 to 7 are dropped at the input and have no
// effect. Only transform items produce a result item. The linear part is
// signed fixed point with FRAC_BITS fraction bits; every product, or sum of
// two products, is 32 bits, shifted right arithmetically by FRAC_BITS and
// wrapped to 16 bits, and all sums wrap. The sine table is a ROM of
// SINE_STEPS entries built at elaboration.
// ----------------------------------------------------------------------------
module affine_2d_matrix_unit #(
    parameter int FRAC_BITS  = afm_pkg::AFM_FRAC_BITS,
    parameter int SINE_STEPS = afm_pkg::AFM_SINE_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] arg_a, [31:16] arg_b
    input  logic        s_axis_tlast,   // last_in
    input  logic [2:0]  s_axis_tuser,   // [2:0] func
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] out_x, [31:16] out_y
    output logic        m_axis_tlast    // last_out
);

    localparam int IW     = $clog2(SINE_STEPS);
    localparam int CMD_W  = $bits(afm_pkg::t_afm_cmd);
    localparam int DATA_W = CMD_W + IW;

    logic              w_push;
    afm_pkg::t_afm_cmd w_f_cmd;
    logic [IW-1:0]     w_f_angle;
    logic              w_full;
    logic              w_pop;
    logic              w_q_vld;
    logic [DATA_W-1:0] w_q_data;
    afm_pkg::t_afm_cmd w_b_cmd;
    logic [IW-1:0]     w_b_angle;
    logic [15:0]       w_out_x;
    logic [15:0]       w_out_y;

    afm_front #(
        .SINE_STEPS (SINE_STEPS),
        .IW         (IW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_func  (s_axis_tuser),
        .i_arg_a (s_axis_tdata[15:0]),
        .i_arg_b (s_axis_tdata[31:16]),
        .i_last  (s_axis_tlast),
        .o_push  (w_push),
        .o_cmd   (w_f_cmd),
        .o_angle (w_f_angle),
        .i_full  (w_full)
    );

    afm_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (afm_pkg::AFM_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_cmd, w_f_angle}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_vld   (w_q_vld),
        .o_data  (w_q_data)
    );

    assign w_b_cmd   = w_q_data[DATA_W-1:IW];
    assign w_b_angle = w_q_data[IW-1:0];

    afm_back #(
        .FRAC_BITS  (FRAC_BITS),
        .SINE_STEPS (SINE_STEPS),
        .IW         (IW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (w_q_vld),
        .i_cmd     (w_b_cmd),
        .i_angle   (w_b_angle),
        .o_pop     (w_pop),
        .o_vld     (m_axis_tvalid),
        .i_rdy     (m_axis_tready),
        .o_x       (w_out_x),
        .o_y       (w_out_y),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {w_out_y, w_out_x};

endmodule

>>> tb/tb_affine_2d_matrix_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_affine_2d_matrix_unit: self-checking bench of the 2-D affine matrix unit
// Sends identity, translate, scale, rotate and point items, mirrors the matrix
// in a bit-exact fixed-point model of its own, and compares every point
// result field by field under random input bursts and output stalls.
// ----------------------------------------------------------------------------
module tb_affine_2d_matrix_unit;

    localparam int FRAC         = afm_pkg::AFM_FRAC_BITS;
    localparam int STEPS        = afm_pkg::AFM_SINE_STEPS;
    localparam int RANDOM_ITEMS = 520;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    // Operation codes that the unit must drop without effect.
    localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

    typedef struct packed {
        logic [15:0] out_x;
        logic [15:0] out_y;
        logic        last;
    } t_point_result;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic        last;
        logic        has_want;
        logic [15:0] want_x;
        logic [15:0] want_y;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [15:0] arg_a, [31:16] arg_b
    logic        s_axis_tlast;    // last_in
    logic [2:0]  s_axis_tuser;    // [2:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [15:0] out_x, [31:16] out_y
    logic        m_axis_tlast;    // last_out

    affine_2d_matrix_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Directed items. Expected values are typed in only where they follow
    // directly from an identity linear part; the rest go through the model.
    t_dir_row dir_rows [0:24] = '{
        '{afm_pkg::OP_TRANSFORM, 16'd100, -16'sd200, 1'b0, 1'b1, 16'd100, -16'sd200},
        '{afm_pkg::OP_TRANSFORM, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h7FFF, 16'h8000},
        '{afm_pkg::OP_TRANSFORM, 16'h8000, 16'h7FFF, 1'b0, 1'b1, 16'h8000, 16'h7FFF},
        '{afm_pkg::OP_TRANSLATE, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'd0, 16'd0},
        // The offset add wraps past the top of the range.
        '{afm_pkg::OP_TRANSFORM, 16'd1, 16'd0, 1'b1, 1'b1, 16'h8000, 16'h8000},
        '{afm_pkg::OP_IDENTITY, 16'd0, 16'd0, 1'b1, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_TRANSFORM, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd0},
        '{afm_pkg::OP_SCALE, 16'd8192, -16'sd4096, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_TRANSFORM, 16'd1000, 16'd1000, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_SCALE, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_TRANSFORM, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'd0, 16'd0},
        '{OP_UNUSED_LO, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 16'd0, 16'd0},
        '{OP_UNUSED_HI, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_TRANSFORM, 16'd3, 16'd3, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_IDENTITY, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_ROTATE, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_ROTATE, 16'd1024, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_ROTATE, 16'd2048, 16'h7FFF, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_ROTATE, 16'hFFFF, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_ROTATE, 16'h7FFF, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_ROTATE, 16'h8000, 16'h8000, 1'b1, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_TRANSFORM, 16'd12345, -16'sd5432, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_TRANSLATE, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'd0, 16'd0},
        '{afm_pkg::OP_TRANSFORM, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 16'd0, 16'd0},
        '{OP_UNUSED_MID, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'd0, 16'd0}
    };

    // Model of the matrix and its sine table.
    logic [15:0] sin_lut [0:STEPS-1];
    logic [15:0] mtx_00, mtx_01, mtx_10, mtx_11;
    logic [15:0] mtx_off_x, mtx_off_y;

    t_point_result point_results_q [$];

    // Typed-in expectation for the item currently offered.
    logic        want_typed;
    logic [15:0] want_x, want_y;

    int mismatch_cnt;
    int sent_cnt;
    int burst_left;
    int hold_req_cnt;
    int cycle_cnt;

    // sin(x) in Q30 for x in Q30 between 0 and pi/2, by Taylor series.
    function automatic longint unsigned taylor_sin_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 9; n++) begin
            term = (term * x2) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return longint'(acc);
    endfunction

    // One table entry, rounded to FRAC fraction bits, half away from zero.
    function automatic logic [15:0] sine_entry(input int idx);
        longint unsigned span, j, n, x, mag;
        logic            neg;
        span = STEPS;
        j    = longint'(idx) % span;
        neg  = 1'b0;
        if (2 * j >= span) begin
            j   = j - span / 2;
            neg = 1'b1;
            if (2 * j >= span) begin
                j = 0;
            end
        end
        n = 2 * j;
        if (2 * n > span) begin
            n = (n <= span) ? span - n : 0;
        end
        x   = (afm_pkg::AFM_PI_Q30 * n + span / 2) / span;
        mag = ((taylor_sin_q30(x) << FRAC) + (64'd1 << 29)) >> 30;
        if (neg) begin
            return 16'(64'h10000 - mag);
        end
        return 16'(mag);
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [15:0] p,
                                                  input logic signed [15:0] q);
        logic signed [31:0] wide_p, wide_q;
        wide_p = p;
        wide_q = q;
        return wide_p * wide_q;
    endfunction

    // Arithmetic shift back to the fixed-point scale, wrapped to 16 bits.
    function automatic logic [15:0] fx_norm(input logic signed [31:0] acc);
        logic signed [31:0] shifted;
        shifted = acc >>> FRAC;
        return shifted[15:0];
    endfunction

    task automatic matrix_reset();
        mtx_00    = 16'(1 << FRAC);
        mtx_01    = 16'd0;
        mtx_10    = 16'd0;
        mtx_11    = 16'(1 << FRAC);
        mtx_off_x = 16'd0;
        mtx_off_y = 16'd0;
    endtask

    // Applies one accepted item to the model; a point item yields its result.
    task automatic apply_matrix_op(input logic [2:0] op, input logic [15:0] a,
                                   input logic [15:0] b, input logic last);
        logic [15:0]   s, c, m00, m01, m10, m11;
        logic [11:0]   angle;
        t_point_result res;
        m00 = mtx_00;
        m01 = mtx_01;
        m10 = mtx_10;
        m11 = mtx_11;
        case (op)
            afm_pkg::OP_IDENTITY: begin
                matrix_reset();
            end
            afm_pkg::OP_TRANSLATE: begin
                mtx_off_x = mtx_off_x + a;
                mtx_off_y = mtx_off_y + b;
            end
            afm_pkg::OP_SCALE: begin
                mtx_00 = fx_norm(fx_mul(m00, a));
                mtx_01 = fx_norm(fx_mul(m01, b));
                mtx_10 = fx_norm(fx_mul(m10, a));
                mtx_11 = fx_norm(fx_mul(m11, b));
            end
            afm_pkg::OP_ROTATE: begin
                angle  = a[11:0];
                s      = sin_lut[angle];
                c      = sin_lut[12'(angle + 12'(STEPS / 4))];
                mtx_00 = fx_norm(fx_mul(m00, c) - fx_mul(m01, s));
                mtx_01 = fx_norm(fx_mul(m00, s) + fx_mul(m01, c));
                mtx_10 = fx_norm(fx_mul(m10, c) - fx_mul(m11, s));
                mtx_11 = fx_norm(fx_mul(m10, s) + fx_mul(m11, c));
            end
            afm_pkg::OP_TRANSFORM: begin
                res.out_x = fx_norm(fx_mul(m00, a) + fx_mul(m01, b)) + mtx_off_x;
                res.out_y = fx_norm(fx_mul(m10, a) + fx_mul(m11, b)) + mtx_off_y;
                res.last  = last;
                if (want_typed) begin
                    res.out_x = want_x;
                    res.out_y = want_y;
                end
                point_results_q.push_back(res);
            end
            default: begin
                // Unused codes leave the matrix alone.
            end
        endcase
    endtask

    // Clock: 12 ns period.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        for (int k = 0; k < STEPS; k++) begin
            sin_lut[k] = sine_entry(k);
        end
    end

    // Model update and result check, both on the values present at the edge.
    always @(posedge i_clk) begin
        t_point_result exp_res;
        if (!i_rst_n) begin
            matrix_reset();
            point_results_q.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_matrix_op(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                                s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (point_results_q.size() == 0) begin
                    $display("%0t: unexpected result x=%h y=%h last=%b", $time,
                             m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast);
                    mismatch_cnt++;
                end else begin
                    exp_res = point_results_q.pop_front();
                    if (m_axis_tdata[15:0] !== exp_res.out_x) begin
                        $display("%0t: out_x expected %h actual %h", $time,
                                 exp_res.out_x, m_axis_tdata[15:0]);
                        mismatch_cnt++;
                    end
                    if (m_axis_tdata[31:16] !== exp_res.out_y) begin
                        $display("%0t: out_y expected %h actual %h", $time,
                                 exp_res.out_y, m_axis_tdata[31:16]);
                        mismatch_cnt++;
                    end
                    if (m_axis_tlast !== exp_res.last) begin
                        $display("%0t: last_out expected %b actual %b", $time,
                                 exp_res.last, m_axis_tlast);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: rotates through stall patterns, and on
    // request holds off for a long stretch so the unit backs up to its input.
    initial begin
        int hold_seen;
        int phase_cnt;
        hold_seen     = 0;
        phase_cnt     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req_cnt != hold_seen) begin
                hold_seen     = hold_req_cnt;
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            phase_cnt++;
            case ((phase_cnt / 50) % 4)
                0:       m_axis_tready = 1'b1;
                1:       m_axis_tready = 1'($urandom_range(0, 1));
                2:       m_axis_tready = (phase_cnt % 4) != 0;
                default: m_axis_tready = ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Offers one item and waits for it to be taken. Items go out in bursts;
    // at the end of a burst the input may go quiet before the next burst.
    task automatic drive_item(input logic [2:0] op, input logic [15:0] a,
                              input logic [15:0] b, input logic last);
        int gap;
        s_axis_tuser  = op;
        s_axis_tdata  = {b, a};
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        want_typed = 1'b0;
        if (op <= afm_pkg::OP_TRANSFORM) begin
            sent_cnt++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Stops offering and waits until every pending point result has arrived.
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (point_results_q.size() != 0) @(negedge i_clk);
    endtask

    // Operand mix: the range ends, values near zero, and anything at all.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:         return 16'h7FFF;
            1:         return 16'h8000;
            2:         return 16'h0000;
            3:         return 16'hFFFF;
            4, 5, 6:   return 16'($urandom_range(0, 2000) - 1000);
            default:   return 16'($urandom);
        endcase
    endfunction

    // Scale factors mostly near plus or minus one so the matrix stays useful.
    function automatic logic [15:0] pick_scale();
        int mag;
        if ($urandom_range(0, 3) == 0) begin
            return pick_word();
        end
        mag = $urandom_range(3500, 4800);
        return ($urandom_range(0, 1) == 1) ? 16'(0 - mag) : 16'(mag);
    endfunction

    task automatic send_matrix_cmd();
        case ($urandom_range(0, 2))
            0:       drive_item(afm_pkg::OP_TRANSLATE, pick_word(), pick_word(),
                                1'($urandom_range(0, 7) == 0));
            1:       drive_item(afm_pkg::OP_SCALE, pick_scale(), pick_scale(),
                                1'($urandom_range(0, 7) == 0));
            default: drive_item(afm_pkg::OP_ROTATE, 16'($urandom), 16'($urandom),
                                1'($urandom_range(0, 7) == 0));
        endcase
    endtask

    initial begin
        int n_pts;
        logic pt_last;
        mismatch_cnt  = 0;
        sent_cnt      = 0;
        burst_left    = 0;
        hold_req_cnt  = 0;
        cycle_cnt     = 0;
        want_typed    = 1'b0;
        want_x        = 16'd0;
        want_y        = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'd0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = afm_pkg::OP_IDENTITY;
        i_rst_n       = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part.
        foreach (dir_rows[r]) begin
            want_typed = dir_rows[r].has_want;
            want_x     = dir_rows[r].want_x;
            want_y     = dir_rows[r].want_y;
            drive_item(dir_rows[r].op, dir_rows[r].arg_a, dir_rows[r].arg_b,
                       dir_rows[r].last);
        end
        wait_drained();

        // Random part: a few matrix commands, then a batch of points that
        // ends on a last flag, with stray unused codes and broken batches.
        sent_cnt = 0;
        while (sent_cnt < RANDOM_ITEMS) begin
            if (hold_req_cnt == 0 && sent_cnt >= RANDOM_ITEMS / 2) begin
                // Let the result side stall for a long while and keep
                // offering points so the unit fills and closes its input.
                wait_drained();
                hold_req_cnt++;
                burst_left = 40;
                for (int k = 0; k < 30; k++) begin
                    drive_item(afm_pkg::OP_TRANSFORM, pick_word(), pick_word(),
                               1'(k == 29));
                end
                wait_drained();
            end
            if ($urandom_range(0, 3) == 0) begin
                drive_item(afm_pkg::OP_IDENTITY, 16'($urandom), 16'($urandom),
                           1'($urandom_range(0, 7) == 0));
            end
            repeat ($urandom_range(0, 3)) send_matrix_cmd();
            n_pts = $urandom_range(1, 12);
            for (int k = 0; k < n_pts; k++) begin
                pt_last = (k == n_pts - 1);
                if ($urandom_range(0, 9) == 0) begin
                    pt_last = 1'($urandom_range(0, 1));
                end
                drive_item(afm_pkg::OP_TRANSFORM, pick_word(), pick_word(), pt_last);
            end
            if ($urandom_range(0, 9) == 0) begin
                drive_item(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                           16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
